// File: sv/tlcd_pkg.sv
// tlcd_pkg: shared types and constants for the turntable limit centering drive
// used by the interfaces, the controller, the datapath and the top level
package tlcd_pkg;

  localparam int FuncWidth     = 3;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;
  localparam int MagCfgWidth   = 15;
  localparam int GainWidth     = 16;
  localparam int GainFracBits  = 8;

  localparam logic [MagCfgWidth-1:0] DefaultPowerReset = 15'd9830;
  localparam logic [MagCfgWidth-1:0] ManualLimitReset  = 15'd9830;
  localparam logic [GainWidth-1:0]   OffsetGainReset   = 16'd256;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ENABLE  = 3'd1,
    FUNC_DISABLE = 3'd2,
    FUNC_CENTER  = 3'd3,
    FUNC_OFFSET  = 3'd4,
    FUNC_MANUAL  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    POS_UNSURE = 2'd0,
    POS_LEFT   = 2'd1,
    POS_CENTER = 2'd2,
    POS_RIGHT  = 2'd3
  } pos_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_RIGHT_IS_POSITIVE = 2'd0,
    CFG_DEFAULT_POWER     = 2'd1,
    CFG_MANUAL_LIMIT      = 2'd2,
    CFG_OFFSET_GAIN       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic                    right_is_positive;
    logic [MagCfgWidth-1:0]  default_power;
    logic [MagCfgWidth-1:0]  manual_limit;
    logic [GainWidth-1:0]    offset_gain;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic mul;
    logic cmp;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic long_op;
    logic mag_ge;
  } dp_stat_t;

endpackage

// File: sv/tlcd_if.sv
// tlcd_if: handshake channels of the turntable drive (input word, result word, config write)
// depends on tlcd_pkg
interface tlcd_in_if import tlcd_pkg::*; #(
  parameter int POWER_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 12
);
  logic                           valid;
  logic                           ready;
  logic [FuncWidth-1:0]           func;
  logic                           left_switch_n;
  logic                           center_switch_n;
  logic                           right_switch_n;
  logic signed [OFFSET_WIDTH-1:0] target_offset;
  logic [OFFSET_WIDTH-1:0]        offset_span;
  logic signed [POWER_WIDTH-1:0]  manual_value;

  modport source (
    output valid, func, left_switch_n, center_switch_n, right_switch_n,
           target_offset, offset_span, manual_value,
    input  ready
  );
  modport sink (
    input  valid, func, left_switch_n, center_switch_n, right_switch_n,
           target_offset, offset_span, manual_value,
    output ready
  );
endinterface

interface tlcd_out_if #(
  parameter int POWER_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [POWER_WIDTH-1:0] motor_power;
  logic [1:0]                    position_code;
  logic                          centering_flag;
  logic                          enabled_flag;

  modport source (
    output valid, motor_power, position_code, centering_flag, enabled_flag,
    input  ready
  );
  modport sink (
    input  valid, motor_power, position_code, centering_flag, enabled_flag,
    output ready
  );
endinterface

interface tlcd_cfg_if import tlcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/turntable_limit_centering_drive.sv
// turntable_limit_centering_drive: top level, config registers, sequencer and datapath
// depends on tlcd_pkg, tlcd_if, tlcd_ctrl, tlcd_dp
//
// Drives a turntable motor between active-low left, center and right limit switches.
// One input word gives exactly one result word, the drive state after that word.
// A tick samples the switches, tracks position and stops the drive against a
// pressed end stop; while centering it drives toward center at default_power.
// Enable, disable and center words only change flags. The manual word sets a
// clamped level. The offset word sets offset * gain / span, capped at +-1.0,
// through a restoring divider that makes one quotient bit per cycle.
// Sequence: tick, flag, manual and zero-span offset words go from accept straight
// to the finish state. An offset word with nonzero span passes accept, multiply,
// compare, POWER_WIDTH - 1 divide steps and finish; a new word is accepted only
// once the last one is through. It takes the short path from compare to finish
// when the product already reaches span full scale.
// The result word is held in the state registers; the next word is accepted
// while it waits and finishes once it has been taken.
// Config writes are always ready and take effect at once.
module turntable_limit_centering_drive import tlcd_pkg::*; #(
  parameter int POWER_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlcd_in_if.sink     in_i,
  tlcd_out_if.source  out_o,
  tlcd_cfg_if.sink    cfg_i
);

  // config registers
  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.right_is_positive <= 1'b0;
      cfg_q.default_power     <= DefaultPowerReset;
      cfg_q.manual_limit      <= ManualLimitReset;
      cfg_q.offset_gain       <= OffsetGainReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_RIGHT_IS_POSITIVE: cfg_q.right_is_positive <= cfg_i.data[0];
        CFG_DEFAULT_POWER:     cfg_q.default_power     <= cfg_i.data[MagCfgWidth-1:0];
        CFG_MANUAL_LIMIT:      cfg_q.manual_limit      <= cfg_i.data[MagCfgWidth-1:0];
        CFG_OFFSET_GAIN:       cfg_q.offset_gain       <= cfg_i.data[GainWidth-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: one word at a time, output valid flag
  tlcd_ctrl #(
    .POWER_WIDTH (POWER_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: latched word, multiplier, divider, drive state
  tlcd_dp #(
    .POWER_WIDTH  (POWER_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_i             (cfg_q),
    .func_i            (in_i.func),
    .left_switch_n_i   (in_i.left_switch_n),
    .center_switch_n_i (in_i.center_switch_n),
    .right_switch_n_i  (in_i.right_switch_n),
    .target_offset_i   (in_i.target_offset),
    .offset_span_i     (in_i.offset_span),
    .manual_value_i    (in_i.manual_value),
    .motor_power_o     (out_o.motor_power),
    .position_code_o   (out_o.position_code),
    .centering_flag_o  (out_o.centering_flag),
    .enabled_flag_o    (out_o.enabled_flag)
  );

endmodule

// File: sv/tlcd_ctrl.sv
// tlcd_ctrl: sequencer for the turntable drive, steps the datapath through one word
// depends on tlcd_pkg
module tlcd_ctrl import tlcd_pkg::*; #(
  parameter int POWER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam int FracBits = POWER_WIDTH - 1;
  localparam int CntWidth = $clog2(FracBits);
  localparam logic [CntWidth-1:0] CntLoad = CntWidth'(FracBits - 1);

  ctrl_state_e         state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.long_op ? ST_MUL : ST_FIN;
        end
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: state_d = stat_i.mag_ge ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.cmp      = (state_q == ST_CMP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.commit   = (state_q == ST_FIN) && slot_free;
    in_ready_o     = (state_q == ST_IDLE);
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == ST_CMP) begin
      cnt_d = CntLoad;
    end else if (state_q == ST_DIV) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/tlcd_dp.sv
// tlcd_dp: drive state, offset multiply and restoring divider, tick/command update
// depends on tlcd_pkg
module tlcd_dp import tlcd_pkg::*; #(
  parameter int POWER_WIDTH  = 16,
  parameter int OFFSET_WIDTH = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctrl_cmd_t                      cmd_i,
  output dp_stat_t                       stat_o,
  input  cfg_t                           cfg_i,
  input  logic [FuncWidth-1:0]           func_i,
  input  logic                           left_switch_n_i,
  input  logic                           center_switch_n_i,
  input  logic                           right_switch_n_i,
  input  logic signed [OFFSET_WIDTH-1:0] target_offset_i,
  input  logic [OFFSET_WIDTH-1:0]        offset_span_i,
  input  logic signed [POWER_WIDTH-1:0]  manual_value_i,
  output logic signed [POWER_WIDTH-1:0]  motor_power_o,
  output logic [1:0]                     position_code_o,
  output logic                           centering_flag_o,
  output logic                           enabled_flag_o
);

  localparam int PW       = POWER_WIDTH;
  localparam int FracBits = PW - 1;
  localparam int MagWidth = OFFSET_WIDTH + GainWidth;
  localparam int DivWidth = OFFSET_WIDTH + GainFracBits;
  localparam int ExtWidth = (PW + 1 > MagCfgWidth + 1) ? PW + 1 : MagCfgWidth + 1;
  localparam logic [ExtWidth-1:0] PwMaxExt =
    {{(ExtWidth - FracBits){1'b0}}, {FracBits{1'b1}}};
  localparam logic [PW-1:0] PwMax = {1'b0, {FracBits{1'b1}}};

  // latched word
  func_e                          func_q;
  logic                           lp_q, cp_q, rp_q;
  logic signed [OFFSET_WIDTH-1:0] off_q;
  logic [OFFSET_WIDTH-1:0]        span_q;
  logic signed [PW-1:0]           man_q;

  // arithmetic registers
  logic [MagWidth-1:0] mag_q;
  logic [DivWidth-1:0] rem_q;
  logic [PW-1:0]       quo_q;

  // drive state, doubles as result register
  logic signed [PW-1:0] level_q, level_d;
  pos_e                 pos_q, pos_d;
  logic                 en_q, en_d;
  logic                 cen_q, cen_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_e'(func_i);
      lp_q   <= ~left_switch_n_i;
      cp_q   <= ~center_switch_n_i;
      rp_q   <= ~right_switch_n_i;
      off_q  <= target_offset_i;
      span_q <= offset_span_i;
      man_q  <= manual_value_i;
    end
  end

  assign stat_o.long_op = (func_i == FUNC_OFFSET) && (offset_span_i != '0);

  // magnitude times q8.8 gain, then compare with span scaled to q12.8
  logic [OFFSET_WIDTH-1:0] off_abs;
  logic [DivWidth-1:0]     divisor;
  assign off_abs = off_q[OFFSET_WIDTH-1] ? OFFSET_WIDTH'(-off_q) : off_q;
  assign divisor = {span_q, {GainFracBits{1'b0}}};
  assign stat_o.mag_ge = mag_q >= {{(MagWidth - DivWidth){1'b0}}, divisor};

  // one quotient bit a step
  logic [DivWidth:0] trial, diff;
  logic              qbit;
  assign trial = {rem_q, 1'b0};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = ~diff[DivWidth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      mag_q <= off_abs * cfg_i.offset_gain;
    end
    if (cmd_i.cmp) begin
      // at or above full scale the quotient caps at 1.0
      quo_q <= stat_o.mag_ge ? {1'b1, {FracBits{1'b0}}} : '0;
      rem_q <= mag_q[DivWidth-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? diff[DivWidth-1:0] : trial[DivWidth-1:0];
      quo_q <= {quo_q[PW-2:0], qbit};
    end
  end

  // offset result
  logic                 off_neg;
  logic signed [PW-1:0] off_level;
  always_comb begin
    off_neg = off_q[OFFSET_WIDTH-1] ^ ~cfg_i.right_is_positive;
    if (span_q == '0) begin
      off_level = '0;
    end else if (off_neg) begin
      off_level = PW'(-quo_q);
    end else begin
      off_level = quo_q[PW-1] ? PwMax : quo_q;
    end
  end

  // capped magnitudes
  logic [ExtWidth-1:0] dp_ext, ml_ext, dp_cap, ml_cap;
  logic [PW-1:0]       dp_pos, dp_neg;
  assign dp_ext = {{(ExtWidth - MagCfgWidth){1'b0}}, cfg_i.default_power};
  assign ml_ext = {{(ExtWidth - MagCfgWidth){1'b0}}, cfg_i.manual_limit};
  assign dp_cap = (dp_ext > PwMaxExt) ? PwMaxExt : dp_ext;
  assign ml_cap = (ml_ext > PwMaxExt) ? PwMaxExt : ml_ext;
  assign dp_pos = dp_cap[PW-1:0];
  assign dp_neg = PW'(-dp_cap);

  // manual result
  logic signed [ExtWidth-1:0] man_x, man_f, lim_s;
  logic signed [PW-1:0]       man_level;
  always_comb begin
    man_x = ExtWidth'(man_q);
    man_f = cfg_i.right_is_positive ? man_x : -man_x;
    lim_s = $signed(ml_cap);
    if (man_f > lim_s) begin
      man_level = lim_s[PW-1:0];
    end else if (man_f < -lim_s) begin
      man_level = PW'(-lim_s);
    end else begin
      man_level = man_f[PW-1:0];
    end
  end

  // tick
  logic lvl_pos, lvl_neg, lvl_zero, to_right, to_left;
  pos_e tick_pos;
  logic signed [PW-1:0] tick_level;
  always_comb begin
    lvl_zero = (level_q == '0);
    lvl_neg  = level_q[PW-1];
    lvl_pos  = !lvl_neg && !lvl_zero;
    to_right = cfg_i.right_is_positive ? lvl_pos : lvl_neg;
    to_left  = cfg_i.right_is_positive ? lvl_neg : lvl_pos;

    priority if (rp_q) begin
      tick_pos = POS_RIGHT;
    end else if (cp_q) begin
      tick_pos = POS_CENTER;
    end else if (lp_q) begin
      tick_pos = POS_LEFT;
    end else if (pos_q == POS_CENTER) begin
      // left center without a switch: infer side from drive direction
      if (to_right) begin
        tick_pos = POS_RIGHT;
      end else if (lvl_zero) begin
        tick_pos = POS_UNSURE;
      end else begin
        tick_pos = POS_LEFT;
      end
    end else begin
      tick_pos = pos_q;
    end

    priority if (!en_q) begin
      tick_level = '0;
    end else if ((to_right && rp_q) || (to_left && lp_q)) begin
      tick_level = '0;
    end else if (cen_q) begin
      unique case (tick_pos)
        POS_UNSURE: tick_level = dp_pos;
        POS_LEFT:   tick_level = cfg_i.right_is_positive ? dp_pos : dp_neg;
        POS_RIGHT:  tick_level = cfg_i.right_is_positive ? dp_neg : dp_pos;
        default:    tick_level = '0;
      endcase
    end else begin
      tick_level = level_q;
    end
  end

  always_comb begin
    level_d = level_q;
    pos_d   = pos_q;
    en_d    = en_q;
    cen_d   = cen_q;
    unique case (func_q)
      FUNC_TICK: begin
        level_d = tick_level;
        pos_d   = tick_pos;
      end
      FUNC_ENABLE:  en_d  = 1'b1;
      FUNC_DISABLE: en_d  = 1'b0;
      FUNC_CENTER:  cen_d = 1'b1;
      FUNC_OFFSET: begin
        level_d = off_level;
        cen_d   = 1'b0;
      end
      FUNC_MANUAL: begin
        level_d = man_level;
        cen_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      pos_q   <= POS_UNSURE;
      en_q    <= 1'b1;
      cen_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      level_q <= level_d;
      pos_q   <= pos_d;
      en_q    <= en_d;
      cen_q   <= cen_d;
    end
  end

  assign motor_power_o    = level_q;
  assign position_code_o  = pos_q;
  assign centering_flag_o = cen_q;
  assign enabled_flag_o   = en_q;

endmodule
